>>> hdl/sdi_pkg.sv
// Package for the SD card SPI-mode initialization sequencer.
// Holds phase codes, command tables and the per-phase CRC7 values.
// No dependencies.
`timescale 1ns / 1ps
package sdi_pkg;

   localparam int IDLE_BYTES = 10;

   localparam logic [4:0] PH_HALT    = 5'd0;
   localparam logic [4:0] PH_CLOCKS  = 5'd1;
   localparam logic [4:0] PH_F_CMD0  = 5'd2;
   localparam logic [4:0] PH_R_CMD0  = 5'd3;
   localparam logic [4:0] PH_F_CMD8  = 5'd4;
   localparam logic [4:0] PH_R_CMD8  = 5'd5;
   localparam logic [4:0] PH_D_R7    = 5'd6;
   localparam logic [4:0] PH_F_V2_55 = 5'd7;
   localparam logic [4:0] PH_R_V2_55 = 5'd8;
   localparam logic [4:0] PH_F_V2_41 = 5'd9;
   localparam logic [4:0] PH_R_V2_41 = 5'd10;
   localparam logic [4:0] PH_F_CMD58 = 5'd11;
   localparam logic [4:0] PH_R_CMD58 = 5'd12;
   localparam logic [4:0] PH_D_OCR   = 5'd13;
   localparam logic [4:0] PH_F_PR_55 = 5'd14;
   localparam logic [4:0] PH_R_PR_55 = 5'd15;
   localparam logic [4:0] PH_F_PR_41 = 5'd16;
   localparam logic [4:0] PH_F_V1_55 = 5'd17;
   localparam logic [4:0] PH_R_V1_55 = 5'd18;
   localparam logic [4:0] PH_F_V1_41 = 5'd19;
   localparam logic [4:0] PH_R_V1_41 = 5'd20;
   localparam logic [4:0] PH_F_CMD16 = 5'd21;
   localparam logic [4:0] PH_R_CMD16 = 5'd22;

   localparam logic [2:0] K_HALT  = 3'd0;
   localparam logic [2:0] K_CLK   = 3'd1;
   localparam logic [2:0] K_FRAME = 3'd2;
   localparam logic [2:0] K_POLL  = 3'd3;
   localparam logic [2:0] K_DATA  = 3'd4;

   localparam logic CSR_RETRY_LIMIT = 1'b0;
   localparam logic CSR_POLL_LIMIT  = 1'b1;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       select_card;
      logic       finished;
      logic [1:0] card_type;
      logic       fast_clock;
   } rsp_type;

   function automatic logic [2:0] phase_kind(input logic [4:0] p);
      logic [2:0] k;
      unique case (p)
         PH_CLOCKS: k = K_CLK;
         PH_F_CMD0, PH_F_CMD8, PH_F_V2_55, PH_F_V2_41, PH_F_CMD58, PH_F_PR_55,
         PH_F_PR_41, PH_F_V1_55, PH_F_V1_41, PH_F_CMD16: k = K_FRAME;
         PH_R_CMD0, PH_R_CMD8, PH_R_V2_55, PH_R_V2_41, PH_R_CMD58, PH_R_PR_55,
         PH_R_V1_55, PH_R_V1_41, PH_R_CMD16: k = K_POLL;
         PH_D_R7, PH_D_OCR: k = K_DATA;
         default: k = K_HALT;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] frame_cmd(input logic [4:0] p);
      logic [7:0] c;
      unique case (p)
         PH_F_CMD0: c = 8'h40;
         PH_F_CMD8: c = 8'h48;
         PH_F_V2_55, PH_F_PR_55, PH_F_V1_55: c = 8'h77;
         PH_F_V2_41, PH_F_PR_41, PH_F_V1_41: c = 8'h69;
         PH_F_CMD58: c = 8'h7A;
         PH_F_CMD16: c = 8'h50;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] frame_arg(input logic [4:0] p);
      logic [31:0] a;
      unique case (p)
         PH_F_CMD8: a = 32'h0000_01AA;
         PH_F_V2_41, PH_F_PR_41: a = 32'h4000_0000;
         PH_F_CMD16: a = 32'h0000_0200;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] b);
      logic [6:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[6] ^ b[i];
         c = {c[5:0], 1'b0};
         if (fb) begin
            c = c ^ 7'h09;
         end
      end
      return c;
   endfunction

   function automatic logic [6:0] frame_crc7(input logic [4:0] p);
      logic [6:0]  c;
      logic [31:0] a;
      a = frame_arg(p);
      c = crc7_byte(7'd0, frame_cmd(p));
      c = crc7_byte(c, a[31:24]);
      c = crc7_byte(c, a[23:16]);
      c = crc7_byte(c, a[15:8]);
      c = crc7_byte(c, a[7:0]);
      return c;
   endfunction

endpackage

>>> hdl/sdi_step.sv
// Next-state and result logic for one received byte of the sequencer.
// Purely combinational; uses sdi_pkg.
`timescale 1ns / 1ps
module sdi_step
   import sdi_pkg::*;
(
   input  logic        command,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] retry_limit,
   input  logic [3:0]  r1_poll_limit,
   input  logic [4:0]  phase,
   input  logic [3:0]  byte_position,
   input  logic [3:0]  poll_count,
   input  logic [15:0] attempts_left,
   input  logic [7:0]  last_reply,
   input  logic [31:0] reply_word,
   input  logic [1:0]  detected_type,
   output logic [4:0]  phase_n,
   output logic [3:0]  byte_position_n,
   output logic [3:0]  poll_count_n,
   output logic [15:0] attempts_left_n,
   output logic [7:0]  last_reply_n,
   output logic [31:0] reply_word_n,
   output logic [1:0]  detected_type_n,
   output rsp_type     rsp
);

   logic [4:0]  ph;
   logic [4:0]  tgt;
   logic        do_go;
   logic        do_fin;
   logic        fin_ok;
   logic        do_emit;
   logic        loop_chk;
   logic        ok;
   logic [7:0]  r;
   logic [2:0]  k;
   logic [2:0]  kt;
   logic [4:0]  ep;
   logic [3:0]  eb;
   logic [2:0]  ek;
   logic [31:0] arg;
   logic [3:0]  plim;

   always_comb begin
      phase_n = phase;
      byte_position_n = byte_position;
      poll_count_n = poll_count;
      attempts_left_n = attempts_left;
      last_reply_n = last_reply;
      reply_word_n = reply_word;
      detected_type_n = detected_type;
      do_go = 1'b0;
      do_fin = 1'b0;
      fin_ok = 1'b0;
      do_emit = 1'b0;
      loop_chk = 1'b0;
      tgt = PH_HALT;
      ok = 1'b0;
      r = last_reply;
      plim = (r1_poll_limit == 4'd0) ? 4'd1 : r1_poll_limit;
      ph = (phase > PH_R_CMD16) ? PH_HALT : phase;
      k = phase_kind(ph);
      if (!command) begin
         detected_type_n = 2'd0;
         attempts_left_n = 16'd0;
         last_reply_n = 8'hFF;
         reply_word_n = 32'd0;
         do_go = 1'b1;
         tgt = PH_CLOCKS;
      end else begin
         unique case (k)
            K_CLK: begin
               if (byte_position < 4'(IDLE_BYTES)) begin
                  do_emit = 1'b1;
               end else begin
                  do_go = 1'b1;
                  tgt = PH_F_CMD0;
               end
            end
            K_FRAME: begin
               if (byte_position < 4'd6) begin
                  do_emit = 1'b1;
               end else if (ph == PH_F_PR_41) begin
                  loop_chk = 1'b1;
                  tgt = PH_F_V1_55;
               end else begin
                  do_go = 1'b1;
                  tgt = ph + 5'd1;
               end
            end
            K_POLL: begin
               if (!rx_byte[7]) begin
                  ok = 1'b1;
                  r = rx_byte;
                  last_reply_n = rx_byte;
               end
               if (!ok && poll_count < plim) begin
                  do_emit = 1'b1;
               end else begin
                  priority case (ph)
                     PH_R_CMD0: begin
                        do_go = ok; do_fin = !ok; tgt = PH_F_CMD8;
                     end
                     PH_R_CMD8: begin
                        if (!ok) begin
                           do_fin = 1'b1;
                        end else begin
                           attempts_left_n = retry_limit;
                           do_go = 1'b1;
                           tgt = r[2] ? PH_F_PR_55 : PH_D_R7;
                        end
                     end
                     PH_R_V2_55, PH_R_V1_55: begin
                        if (ok && r[7:1] == 7'd0) begin
                           do_go = 1'b1;
                           tgt = ph + 5'd1;
                        end else begin
                           do_fin = 1'b1;
                        end
                     end
                     PH_R_V2_41, PH_R_V1_41: begin
                        if (!ok) begin
                           do_fin = 1'b1;
                        end else begin
                           attempts_left_n = attempts_left - 16'd1;
                           if (r == 8'd0) begin
                              do_go = 1'b1;
                              tgt = (ph == PH_R_V2_41) ? PH_F_CMD58 : PH_F_CMD16;
                           end else begin
                              loop_chk = 1'b1;
                              tgt = (ph == PH_R_V2_41) ? PH_F_V2_55 : PH_F_V1_55;
                           end
                        end
                     end
                     PH_R_CMD58: begin
                        do_go = ok; do_fin = !ok; tgt = PH_D_OCR;
                     end
                     PH_R_PR_55: begin
                        if (!ok) begin
                           loop_chk = 1'b1;
                           tgt = PH_F_V1_55;
                        end else if (r[7:1] != 7'd0) begin
                           do_fin = 1'b1;
                        end else begin
                           do_go = 1'b1;
                           tgt = PH_F_PR_41;
                        end
                     end
                     PH_R_CMD16: begin
                        do_fin = 1'b1;
                        if (ok) begin
                           detected_type_n = 2'd1;
                           fin_ok = 1'b1;
                        end
                     end
                     default: do_fin = 1'b1;
                  endcase
               end
            end
            K_DATA: begin
               reply_word_n = {reply_word[23:0], rx_byte};
               if (byte_position < 4'd4) begin
                  do_emit = 1'b1;
               end else if (ph == PH_D_R7) begin
                  if (reply_word_n[15:0] == 16'h01AA) begin
                     loop_chk = 1'b1;
                     tgt = PH_F_V2_55;
                  end else begin
                     do_fin = 1'b1;
                  end
               end else begin
                  detected_type_n = reply_word_n[30] ? 2'd3 : 2'd2;
                  do_fin = 1'b1;
                  fin_ok = 1'b1;
               end
            end
            default: begin
               phase_n = ph;
            end
         endcase
      end
      if (loop_chk) begin
         if (attempts_left_n == 16'd0) begin
            do_fin = 1'b1;
         end else begin
            do_go = 1'b1;
         end
      end
      if (do_fin) begin
         if (!fin_ok) begin
            detected_type_n = 2'd0;
         end
         phase_n = PH_HALT;
         byte_position_n = 4'd0;
         poll_count_n = 4'd0;
      end
      ep = do_go ? tgt : ph;
      eb = do_go ? 4'd0 : byte_position;
      kt = phase_kind(tgt);
      if (do_go) begin
         phase_n = tgt;
         poll_count_n = 4'd0;
         if (kt == K_DATA) begin
            reply_word_n = 32'd0;
         end
      end
      ek = (do_go || do_emit) ? phase_kind(ep) : K_HALT;
      arg = frame_arg(ep);
      rsp.tx_byte = 8'hFF;
      rsp.select_card = 1'b0;
      rsp.finished = 1'b0;
      rsp.card_type = 2'd0;
      rsp.fast_clock = 1'b0;
      unique case (ek)
         K_FRAME: begin
            rsp.select_card = 1'b1;
            byte_position_n = eb + 4'd1;
            unique case (eb)
               4'd0: rsp.tx_byte = frame_cmd(ep);
               4'd1: rsp.tx_byte = arg[31:24];
               4'd2: rsp.tx_byte = arg[23:16];
               4'd3: rsp.tx_byte = arg[15:8];
               4'd4: rsp.tx_byte = arg[7:0];
               default: rsp.tx_byte = {frame_crc7(ep), 1'b1};
            endcase
         end
         K_POLL: begin
            rsp.select_card = 1'b1;
            byte_position_n = eb;
            poll_count_n = (do_go ? 4'd0 : poll_count) + 4'd1;
         end
         K_DATA, K_CLK: begin
            rsp.select_card = (ek == K_DATA);
            byte_position_n = eb + 4'd1;
         end
         default: begin
            rsp.finished = 1'b1;
            rsp.card_type = detected_type_n;
            rsp.fast_clock = (detected_type_n != 2'd0);
         end
      endcase
   end

endmodule

>>> hdl/sd_spi_card_init_sequencer_unit.sv
// SD card SPI-mode initialization sequencer: top level.
// Holds state, configuration and the result register; uses sdi_pkg and sdi_step.
//
// Usage: the req_ channel carries one transaction per SPI byte. A command of 0
// starts initialization; a command of 1 delivers the byte received from the
// card during the previously sent byte. Each request yields exactly one
// response on the rsp_ channel: the next byte to send, the chip-select level,
// and, once the sequence ends, the finished flag, card type and fast clock.
// The response register is loaded when a request is accepted, so the response is valid in the
// cycle after, and the block takes one request per cycle while req_stall is low; the state update
// is a single pass of logic between the state registers and the response register.
// When rsp_stall is high the response holds and req_stall rises only if a
// response is already waiting, so a new request is taken whenever the
// response register is empty or is being drained in the same cycle.
// Reset puts the sequencer in the halted state with the registers at
// retry_limit 300 and r1_poll_limit 3; configuration writes are always ready.
`timescale 1ns / 1ps
module sd_spi_card_init_sequencer_unit
   import sdi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_select_card,
   output logic        rsp_finished,
   output logic [1:0]  rsp_card_type,
   output logic        rsp_fast_clock,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0] retry_ff, retry_in;
   logic [3:0]  plim_ff, plim_in;
   logic [4:0]  phase_ff, phase_in;
   logic [3:0]  bpos_ff, bpos_in;
   logic [3:0]  pcnt_ff, pcnt_in;
   logic [15:0] att_ff, att_in;
   logic [7:0]  last_ff, last_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  dtype_ff, dtype_in;
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   rsp_type     step_rsp;
   logic        take;

   assign csr_ready = 1'b1;
   assign req_stall = valid_ff && rsp_stall;
   assign take = req_valid && !req_stall;

   sdi_step u_step (
      .command(req_command), .rx_byte(req_rx_byte),
      .retry_limit(retry_ff), .r1_poll_limit(plim_ff),
      .phase(phase_ff), .byte_position(bpos_ff), .poll_count(pcnt_ff),
      .attempts_left(att_ff), .last_reply(last_ff), .reply_word(word_ff),
      .detected_type(dtype_ff),
      .phase_n(phase_in), .byte_position_n(bpos_in), .poll_count_n(pcnt_in),
      .attempts_left_n(att_in), .last_reply_n(last_in), .reply_word_n(word_in),
      .detected_type_n(dtype_in), .rsp(step_rsp)
   );

   always_comb begin
      retry_in = retry_ff;
      plim_in = plim_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RETRY_LIMIT: retry_in = csr_data;
            CSR_POLL_LIMIT:  plim_in = csr_data[3:0];
            default: retry_in = retry_ff;
         endcase
      end
      valid_in = take || (valid_ff && rsp_stall);
      rsp_in = take ? step_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= 16'd300;
         plim_ff <= 4'd3;
         phase_ff <= PH_HALT;
         bpos_ff <= 4'd0;
         pcnt_ff <= 4'd0;
         att_ff <= 16'd0;
         last_ff <= 8'hFF;
         word_ff <= 32'd0;
         dtype_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         retry_ff <= retry_in;
         plim_ff <= plim_in;
         valid_ff <= valid_in;
         if (take) begin
            phase_ff <= phase_in;
            bpos_ff <= bpos_in;
            pcnt_ff <= pcnt_in;
            att_ff <= att_in;
            last_ff <= last_in;
            word_ff <= word_in;
            dtype_ff <= dtype_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_tx_byte = rsp_ff.tx_byte;
   assign rsp_select_card = rsp_ff.select_card;
   assign rsp_finished = rsp_ff.finished;
   assign rsp_card_type = rsp_ff.card_type;
   assign rsp_fast_clock = rsp_ff.fast_clock;

endmodule
